### rtl/core/mlrs_pkg.sv
// ----------------------------------------------------------------------------
// mlrs_pkg
// Shared types, codes and tables for the mixer level register sequencer.
// ----------------------------------------------------------------------------
package mlrs_pkg;

  localparam int NUM_CTRL   = 8;
  localparam int CTRL_W     = 3;
  localparam int LVL_W      = 7;
  localparam int NUM_WRITES = 23;
  localparam int STEP_W     = 5;
  localparam int MASK_W     = 7;

  localparam logic [LVL_W-1:0]  LVL_MAX   = 7'd100;
  localparam logic [LVL_W-1:0]  LVL_DEF   = 7'd50;
  localparam logic [STEP_W-1:0] STEP_LAST = 5'(NUM_WRITES - 1);
  localparam logic [7:0]        TONE_BASE = 8'd78;

  localparam logic [1:0] KIND_SET     = 2'd0;
  localparam logic [1:0] KIND_RESTORE = 2'd1;

  localparam logic [CTRL_W-1:0] CTL_AUDIO  = 3'd0;
  localparam logic [CTRL_W-1:0] CTL_SYNTH  = 3'd1;
  localparam logic [CTRL_W-1:0] CTL_CD     = 3'd2;
  localparam logic [CTRL_W-1:0] CTL_LINE   = 3'd3;
  localparam logic [CTRL_W-1:0] CTL_MIC    = 3'd4;
  localparam logic [CTRL_W-1:0] CTL_SPK    = 3'd5;
  localparam logic [CTRL_W-1:0] CTL_TREBLE = 3'd6;
  localparam logic [CTRL_W-1:0] CTL_BASS   = 3'd7;

  localparam logic [2:0] SEL_FF       = 3'd0;
  localparam logic [2:0] SEL_ZERO     = 3'd1;
  localparam logic [2:0] SEL_VOL_L    = 3'd2;
  localparam logic [2:0] SEL_VOL_R    = 3'd3;
  localparam logic [2:0] SEL_TONE_L   = 3'd4;
  localparam logic [2:0] SEL_TONE_R   = 3'd5;
  localparam logic [2:0] SEL_MASK_OUT = 3'd6;
  localparam logic [2:0] SEL_MASK     = 3'd7;

  typedef struct packed {
    logic [LVL_W-1:0] l_in;
    logic [LVL_W-1:0] r_in;
    logic [LVL_W-1:0] l_out;
    logic [LVL_W-1:0] r_out;
  } lvl_word_t;

  typedef struct packed {
    logic [7:0]        addr;
    logic [2:0]        sel;
    logic [CTRL_W-1:0] ctl;
    logic              mask_en;
    logic [2:0]        mask_bit;
  } step_t;

  typedef struct packed {
    logic              start;
    logic              load;
    logic [STEP_W-1:0] step;
    logic              cap;
  } seq_ctrl_t;

  function automatic step_t step_info(input logic [STEP_W-1:0] s);
    step_t t;
    t = '{addr: 8'h30, sel: SEL_FF, ctl: CTL_AUDIO, mask_en: 1'b0, mask_bit: 3'd0};
    case (s)
      5'd0:  t.addr = 8'h30;
      5'd1:  t.addr = 8'h31;
      5'd2:  begin t.addr = 8'h3f; t.sel = SEL_ZERO; end
      5'd3:  begin t.addr = 8'h40; t.sel = SEL_ZERO; end
      5'd4:  begin t.addr = 8'h41; t.sel = SEL_ZERO; end
      5'd5:  begin t.addr = 8'h42; t.sel = SEL_ZERO; end
      5'd6:  t = '{8'h32, SEL_VOL_L, CTL_AUDIO, 1'b1, 3'd4};
      5'd7:  t = '{8'h33, SEL_VOL_R, CTL_AUDIO, 1'b1, 3'd3};
      5'd8:  t = '{8'h34, SEL_VOL_L, CTL_SYNTH, 1'b1, 3'd6};
      5'd9:  t = '{8'h35, SEL_VOL_R, CTL_SYNTH, 1'b1, 3'd5};
      5'd10: t = '{8'h36, SEL_VOL_L, CTL_CD, 1'b1, 3'd2};
      5'd11: t = '{8'h37, SEL_VOL_R, CTL_CD, 1'b1, 3'd1};
      5'd12: t = '{8'h38, SEL_VOL_L, CTL_LINE, 1'b0, 3'd0};
      5'd13: t = '{8'h39, SEL_VOL_R, CTL_LINE, 1'b0, 3'd0};
      5'd14: t = '{8'h3a, SEL_VOL_L, CTL_MIC, 1'b1, 3'd0};
      5'd15: t = '{8'h3b, SEL_VOL_L, CTL_SPK, 1'b0, 3'd0};
      5'd16: t = '{8'h44, SEL_TONE_L, CTL_TREBLE, 1'b0, 3'd0};
      5'd17: t = '{8'h45, SEL_TONE_R, CTL_TREBLE, 1'b0, 3'd0};
      5'd18: t = '{8'h46, SEL_TONE_L, CTL_BASS, 1'b0, 3'd0};
      5'd19: t = '{8'h47, SEL_TONE_R, CTL_BASS, 1'b0, 3'd0};
      5'd20: begin t.addr = 8'h3c; t.sel = SEL_MASK_OUT; end
      5'd21: begin t.addr = 8'h3d; t.sel = SEL_MASK; end
      5'd22: begin t.addr = 8'h3e; t.sel = SEL_MASK; end
      default: t.sel = SEL_ZERO;
    endcase
    return t;
  endfunction

  function automatic lvl_word_t default_word(input logic [CTRL_W-1:0] c);
    logic [LVL_W-1:0] d;
    d = (c == CTL_AUDIO || c == CTL_TREBLE || c == CTL_BASS) ? LVL_DEF : '0;
    return '{l_in: d, r_in: d, l_out: d, r_out: d};
  endfunction

  // v*255/100 for v in 0..100 as (v*51)/20, the divide by 20 as (x*3277) >> 16
  function automatic logic [7:0] scale_vol(input logic [LVL_W-1:0] v);
    logic [12:0] p;
    logic [23:0] q;
    p = 13'(v) * 13'd51;
    q = 24'(p) * 24'd3277;
    return q[23:16];
  endfunction

endpackage

### rtl/core/mlrs_level_ram.sv
// ----------------------------------------------------------------------------
// mlrs_level_ram
// Level store: one word per control with all four tables, registered read,
// write forwarding and per-entry valid bits that fall back to defaults.
// ----------------------------------------------------------------------------
module mlrs_level_ram
  import mlrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CTRL_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [CTRL_W-1:0] wr_addr,
  input  lvl_word_t         wr_data,
  input  logic              clr,
  output lvl_word_t         rd_word
);

  lvl_word_t         mem_r [NUM_CTRL];
  lvl_word_t         rdata_r;
  logic [CTRL_W-1:0] raddr_r;
  logic [NUM_CTRL-1:0] vld_r;
  logic              rvld_r;
  logic              fwd;

  assign fwd = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rdata_r <= fwd ? wr_data : mem_r[rd_addr];
    raddr_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (clr) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rvld_r <= fwd ? 1'b1 : (clr ? 1'b0 : vld_r[rd_addr]);
    end
  end

  assign rd_word = rvld_r ? rdata_r : default_word(raddr_r);

endmodule

### rtl/core/mlrs_write_gen.sv
// ----------------------------------------------------------------------------
// mlrs_write_gen
// Builds the address and data of each mixer write from the step table and
// the level word; gathers the source mask along the volume steps.
// ----------------------------------------------------------------------------
module mlrs_write_gen
  import mlrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  seq_ctrl_t  ctrl,
  input  lvl_word_t  word,
  output logic [7:0] wr_addr,
  output logic [7:0] wr_data,
  output logic       wr_last
);

  step_t             info;
  logic [LVL_W-1:0]  lt;
  logic [LVL_W-1:0]  rt;
  logic [LVL_W-1:0]  lvl;
  logic [MASK_W-1:0] src_r;
  logic [MASK_W-1:0] src_nxt;

  assign info = step_info(ctrl.step);
  assign lt   = ctrl.cap ? word.l_in : word.l_out;
  assign rt   = ctrl.cap ? word.r_in : word.r_out;
  assign lvl  = (info.sel == SEL_VOL_R) ? rt : lt;

  always_comb begin
    src_nxt = src_r;
    if (ctrl.start) begin
      src_nxt = '0;
    end else if (ctrl.load && info.mask_en && (lvl != '0)) begin
      src_nxt[info.mask_bit] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= '0;
    end else begin
      src_r <= src_nxt;
    end
  end

  always_comb begin
    case (info.sel)
      SEL_FF:       wr_data = 8'hff;
      SEL_ZERO:     wr_data = 8'h00;
      SEL_VOL_L:    wr_data = scale_vol(lt);
      SEL_VOL_R:    wr_data = scale_vol(rt);
      SEL_TONE_L:   wr_data = TONE_BASE + 8'(lt);
      SEL_TONE_R:   wr_data = TONE_BASE + 8'(rt);
      SEL_MASK_OUT: wr_data = ctrl.cap ? 8'h00 : {1'b0, src_r};
      SEL_MASK:     wr_data = {1'b0, src_r};
      default:      wr_data = 8'h00;
    endcase
  end

  assign wr_addr = info.addr;
  assign wr_last = (ctrl.step == STEP_LAST);

endmodule

### rtl/core/mixer_level_register_sequencer_unit.sv
// ----------------------------------------------------------------------------
// mixer_level_register_sequencer_unit
// Keeps input and output left/right levels for eight mixer controls and
// emits the 23-word mixer programming sequence for every input word.
//
// Input channel (in_*): one command word: set a level, restore defaults, or
// reissue only. Accepted only while no sequence is running.
// Output channel (out_*): 23 words of register address and data, out_last
// on the final one, one word per cycle while the receiver takes them.
// Config (cfg_*): capture_mode, written at any edge with cfg_wr_en high.
// For a set, the level word is first read, updated and written back in ST_UPD;
// every command then loads its writes in turn into the output register in ST_EMIT.
// A new command is taken only once the last write has been loaded; the level
// store has a single read port and the 23 writes are made one at a time.
// Reset: levels return to defaults (50 for audio, treble, bass, else 0),
// capture_mode clears, the output register empties.
// A stalled receiver holds the output word; the sequence waits in place.
// ----------------------------------------------------------------------------
module mixer_level_register_sequencer_unit
  import mlrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [2:0]  in_control,
  input  logic        in_to_left,
  input  logic        in_to_right,
  input  logic        in_to_input,
  input  logic        in_to_output,
  input  logic [15:0] in_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_mixer_address,
  output logic [7:0]  out_mixer_data,
  output logic        out_last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              cap_r;
  logic [CTRL_W-1:0] ctl_r;
  logic              l_r, r_r, ti_r, to_r;
  logic [LVL_W-1:0]  lvl_r;
  logic              out_valid_r;
  logic [7:0]        out_addr_r, out_data_r;
  logic              out_last_r;

  logic              accept, load;
  logic [CTRL_W-1:0] rd_addr;
  lvl_word_t         rd_word, wr_word;
  seq_ctrl_t         ctrl;
  logic [7:0]        g_addr, g_data;
  logic              g_last;
  step_t             nxt_info;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign load     = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_kind == KIND_SET) ? ST_UPD : ST_EMIT;
          step_nxt  = '0;
        end
      end
      ST_UPD: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (load) begin
          if (step_r == STEP_LAST) begin
            state_nxt = ST_IDLE;
            step_nxt  = '0;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign nxt_info = step_info(step_nxt);
  assign rd_addr  = (state_r == ST_IDLE) ? in_control : nxt_info.ctl;

  always_comb begin
    wr_word = rd_word;
    if (l_r && to_r) wr_word.l_out = lvl_r;
    if (l_r && ti_r) wr_word.l_in  = lvl_r;
    if (r_r && to_r) wr_word.r_out = lvl_r;
    if (r_r && ti_r) wr_word.r_in  = lvl_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      cap_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctl_r <= in_control;
      l_r   <= in_to_left;
      r_r   <= in_to_right;
      ti_r  <= in_to_input;
      to_r  <= in_to_output;
      lvl_r <= (in_level > 16'(LVL_MAX)) ? LVL_MAX : in_level[LVL_W-1:0];
    end
    if (load) begin
      out_addr_r <= g_addr;
      out_data_r <= g_data;
      out_last_r <= g_last;
    end
  end

  mlrs_level_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .wr_en   (state_r == ST_UPD),
    .wr_addr (ctl_r),
    .wr_data (wr_word),
    .clr     (accept && (in_kind == KIND_RESTORE)),
    .rd_word (rd_word)
  );

  assign ctrl = '{start: accept, load: load, step: step_r, cap: cap_r};

  mlrs_write_gen u_gen (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .word    (rd_word),
    .wr_addr (g_addr),
    .wr_data (g_data),
    .wr_last (g_last)
  );

  assign out_valid         = out_valid_r;
  assign out_mixer_address = out_addr_r;
  assign out_mixer_data    = out_data_r;
  assign out_last          = out_last_r;

endmodule

### rtl/core/mlrs_checker.sv
// ----------------------------------------------------------------------------
// mlrs_checker
// Port-level checks for the mixer level register sequencer, bound to the top.
// ----------------------------------------------------------------------------
module mlrs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_mixer_address,
  input logic [7:0] out_mixer_data,
  input logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mixer_address)
      && $stable(out_mixer_data) && $stable(out_last))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while sequence running");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_last_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_last != (out_mixer_address == 8'h3e)) |-> 1'b0)
    else $error("last flag and final register disagree");

endmodule

bind mixer_level_register_sequencer_unit mlrs_checker u_mlrs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_mixer_address (out_mixer_address),
  .out_mixer_data    (out_mixer_data),
  .out_last          (out_last)
);
